// ----- hdl/nqt_pkg.sv -----
// Types and constants shared by the node quarantine table modules.
package nqt_pkg;

    // action codes
    localparam logic [1:0] ACT_ADMIT   = 2'd0;
    localparam logic [1:0] ACT_VERDICT = 2'd1;
    localparam logic [1:0] ACT_EXPEL   = 2'd2;
    localparam logic [1:0] ACT_QUERY   = 2'd3;

    // result status codes
    localparam logic [1:0] STS_OK      = 2'd0;
    localparam logic [1:0] STS_MISS    = 2'd1;
    localparam logic [1:0] STS_REFUSED = 2'd2;
    localparam logic [1:0] STS_FULL    = 2'd3;

    // slot states
    localparam logic [1:0] SLOT_EMPTY  = 2'd0;
    localparam logic [1:0] SLOT_VERIFY = 2'd1;
    localparam logic [1:0] SLOT_CLEAN  = 2'd2;
    localparam logic [1:0] SLOT_MALIC  = 2'd3;

    // motives
    localparam logic [1:0] MOT_UNKNOWN = 2'd0;
    localparam logic [1:0] MOT_INVALID = 2'd3;

    // register byte addresses
    localparam logic [1:0] REG_ENABLE  = 2'd0;

    localparam int TW = 48;

    typedef struct packed {
        logic [1:0]    action;
        logic [7:0]    node;
        logic [1:0]    motive;
        logic          verdict;
        logic [TW-1:0] now_ms;
    } nqt_in_t;

    typedef struct packed {
        logic [1:0]    status;
        logic [1:0]    entry_state;
        logic [1:0]    entry_motive;
        logic [TW-1:0] arrival_ms;
        logic [TW-1:0] verdict_ms;
        logic [3:0]    active_count;
    } nqt_out_t;

    // one memory word per slot; the slot state lives in flops beside it
    typedef struct packed {
        logic [7:0]    node;
        logic [1:0]    motive;
        logic [TW-1:0] arrival;
        logic [TW-1:0] judged;
    } slot_word_t;

endpackage

// ----- hdl/nqt_apb.sv -----
// APB configuration register block for the node quarantine table.
module nqt_apb (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic        enable
);
    import nqt_pkg::*;

    logic enable_reg;
    logic enable_next;
    logic wr_hit;

    assign wr_hit = psel && penable && pwrite && (paddr == REG_ENABLE);

    always_comb
    begin
        enable_next = enable_reg;
        if (wr_hit)
        begin
            enable_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
        end
        else
        begin
            enable_reg <= enable_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr == REG_ENABLE)
        begin
            prdata[0] = enable_reg;
        end
    end

    assign pready = 1'b1;
    assign enable = enable_reg;

endmodule

// ----- hdl/nqt_store.sv -----
// Slot store: synchronous word memory plus per-slot state flops.
module nqt_store #(
    parameter int DEPTH = 8,
    parameter int IW    = 3
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [IW-1:0]       rd_addr,
    output nqt_pkg::slot_word_t rd_word,
    output logic [1:0]          rd_state,
    input  logic                wr_en,
    input  logic [IW-1:0]       wr_addr,
    input  nqt_pkg::slot_word_t wr_word,
    input  logic                st_we,
    input  logic [1:0]          st_wdata
);
    import nqt_pkg::*;

    slot_word_t mem [DEPTH];
    logic [1:0] state_reg [DEPTH];
    slot_word_t rd_word_reg;
    logic [1:0] rd_state_reg;

    // words of empty slots are never used, so the memory needs no clearing
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_word;
        end
        rd_word_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                state_reg[i] <= SLOT_EMPTY;
            end
            rd_state_reg <= SLOT_EMPTY;
        end
        else
        begin
            if (st_we)
            begin
                state_reg[wr_addr] <= st_wdata;
            end
            rd_state_reg <= state_reg[rd_addr];
        end
    end

    assign rd_word  = rd_word_reg;
    assign rd_state = rd_state_reg;

endmodule

// ----- hdl/node_quarantine_table_core.sv -----
// Top level of the node quarantine table: action sequencer around the slot store.
// An action is taken when start is high and busy is low. The sequencer scans the
// slots one per cycle through the store's single read port, stopping at the
// first slot that holds the node, then enters an execute step that writes back
// and registers the result. done is high for a single cycle with the result on
// result, and busy drops on the cycle done rises, so a new action can be taken
// then. The receiver cannot stall. The enable register sits at byte address 0.
module node_quarantine_table_core #(
    parameter int TABLE_DEPTH = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [1:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              start,
    output logic              busy,
    input  nqt_pkg::nqt_in_t  cmd,
    output logic              done,
    output nqt_pkg::nqt_out_t result
);
    import nqt_pkg::*;

    localparam int IW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW  = $clog2(TABLE_DEPTH + 1);
    localparam int CWX = (CW > 4) ? CW : 4;
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_EXEC} state_t;

    state_t     state_reg, state_next;
    logic       done_reg, done_next;
    nqt_out_t   result_reg, result_next;
    logic [IW-1:0] scan_idx_reg, scan_idx_next;
    logic       hit_reg, hit_next;
    logic       free_found_reg, free_found_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    // payload registers
    nqt_in_t    cmd_reg;
    logic [IW-1:0] hit_idx_reg;
    slot_word_t hit_word_reg;
    logic [1:0] hit_state_reg;
    logic [IW-1:0] free_idx_reg;

    logic       enable;
    logic [IW-1:0] rd_addr;
    slot_word_t rd_word;
    logic [1:0] rd_state;
    logic       wr_en;
    logic [IW-1:0] wr_addr;
    slot_word_t wr_word;
    logic       st_we;
    logic [1:0] st_wdata;

    nqt_in_t    cmd_in;
    logic       accept;
    logic       cur_match;
    logic       cur_empty;
    logic       last;
    logic       inc;
    logic       dec;
    logic [1:0] sts;
    logic       old_active;
    logic       new_active;
    logic [CWX-1:0] cnt_wide;

    nqt_apb u_apb (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .enable  (enable)
    );

    nqt_store #(
        .DEPTH (TABLE_DEPTH),
        .IW    (IW)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_addr  (rd_addr),
        .rd_word  (rd_word),
        .rd_state (rd_state),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_word  (wr_word),
        .st_we    (st_we),
        .st_wdata (st_wdata)
    );

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;
    assign last   = (scan_idx_reg == LAST_IDX);

    // read data in S_SCAN belongs to scan_idx_reg; next address is issued ahead
    always_comb
    begin
        if (state_reg == S_IDLE || last)
        begin
            rd_addr = '0;
        end
        else
        begin
            rd_addr = scan_idx_reg + 1'b1;
        end
    end

    assign cur_empty = (rd_state == SLOT_EMPTY);
    assign cur_match = !cur_empty && (rd_word.node == cmd_reg.node);

    // an undefined motive code counts as unknown
    always_comb
    begin
        cmd_in = cmd;
        if (cmd.motive == MOT_INVALID)
        begin
            cmd_in.motive = MOT_UNKNOWN;
        end
    end

    // execute step: write-back and result formation
    always_comb
    begin
        wr_en      = 1'b0;
        wr_addr    = hit_idx_reg;
        wr_word    = hit_word_reg;
        st_we      = 1'b0;
        st_wdata   = hit_state_reg;
        inc        = 1'b0;
        dec        = 1'b0;
        sts        = STS_OK;
        old_active = (hit_state_reg == SLOT_VERIFY) || (hit_state_reg == SLOT_CLEAN);
        new_active = !cmd_reg.verdict;
        result_next = '0;
        case (cmd_reg.action)
            ACT_ADMIT:
            begin
                if (!enable)
                begin
                    sts = STS_MISS;
                end
                else if (hit_reg)
                begin
                    if (hit_state_reg == SLOT_MALIC)
                    begin
                        sts = STS_REFUSED;
                    end
                    else if (hit_word_reg.motive == MOT_UNKNOWN
                             && cmd_reg.motive != MOT_UNKNOWN)
                    begin
                        wr_en          = 1'b1;
                        wr_word.motive = cmd_reg.motive;
                    end
                end
                else if (free_found_reg)
                begin
                    wr_en           = 1'b1;
                    wr_addr         = free_idx_reg;
                    wr_word.node    = cmd_reg.node;
                    wr_word.motive  = cmd_reg.motive;
                    wr_word.arrival = cmd_reg.now_ms;
                    wr_word.judged  = '0;
                    st_we           = 1'b1;
                    st_wdata        = SLOT_VERIFY;
                    inc             = 1'b1;
                end
                else
                begin
                    sts = STS_FULL;
                end
            end
            ACT_VERDICT:
            begin
                if (!hit_reg)
                begin
                    sts = STS_MISS;
                end
                else
                begin
                    wr_en          = 1'b1;
                    wr_word.judged = cmd_reg.now_ms;
                    st_we          = 1'b1;
                    st_wdata       = cmd_reg.verdict ? SLOT_MALIC : SLOT_CLEAN;
                    inc            = new_active && !old_active;
                    dec            = old_active && !new_active;
                end
            end
            ACT_EXPEL:
            begin
                if (!hit_reg)
                begin
                    sts = STS_MISS;
                end
                else
                begin
                    st_we    = 1'b1;
                    st_wdata = SLOT_EMPTY;
                    dec      = old_active;
                end
            end
            default:
            begin
                if (!hit_reg)
                begin
                    sts = STS_MISS;
                end
                else
                begin
                    result_next.entry_state  = hit_state_reg;
                    result_next.entry_motive = hit_word_reg.motive;
                    result_next.arrival_ms   = hit_word_reg.arrival;
                    result_next.verdict_ms   = hit_word_reg.judged;
                end
            end
        endcase
        if (state_reg != S_EXEC)
        begin
            wr_en = 1'b0;
            st_we = 1'b0;
            inc   = 1'b0;
            dec   = 1'b0;
        end
        cnt_next = cnt_reg + CW'(inc) - CW'(dec);
        cnt_wide = CWX'(cnt_next);
        result_next.status       = sts;
        result_next.active_count = (cnt_wide > CWX'(15)) ? 4'd15 : cnt_wide[3:0];
    end

    always_comb
    begin
        state_next      = state_reg;
        done_next       = 1'b0;
        scan_idx_next   = scan_idx_reg;
        hit_next        = hit_reg;
        free_found_next = free_found_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next      = S_SCAN;
                    scan_idx_next   = '0;
                    hit_next        = 1'b0;
                    free_found_next = 1'b0;
                end
            end
            S_SCAN:
            begin
                if (cur_empty)
                begin
                    free_found_next = 1'b1;
                end
                if (cur_match)
                begin
                    hit_next   = 1'b1;
                    state_next = S_EXEC;
                end
                else if (last)
                begin
                    state_next = S_EXEC;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
                done_next  = 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            done_reg       <= 1'b0;
            result_reg     <= '0;
            scan_idx_reg   <= '0;
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            cnt_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            done_reg       <= done_next;
            scan_idx_reg   <= scan_idx_next;
            hit_reg        <= hit_next;
            free_found_reg <= free_found_next;
            cnt_reg        <= cnt_next;
            if (state_reg == S_EXEC)
            begin
                result_reg <= result_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd_in;
        end
        if (state_reg == S_SCAN)
        begin
            if (cur_match)
            begin
                hit_idx_reg   <= scan_idx_reg;
                hit_word_reg  <= rd_word;
                hit_state_reg <= rd_state;
            end
            if (cur_empty && !free_found_reg)
            begin
                free_idx_reg <= scan_idx_reg;
            end
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

`ifndef SYNTH
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("accepted transaction did not raise busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while sequencer busy");

    a_done_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == S_EXEC))
        else $error("result strobe without execute step");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        CWX'(cnt_reg) <= CWX'(TABLE_DEPTH))
        else $error("active count exceeds table depth");

    a_write_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en || st_we) |-> (state_reg == S_EXEC))
        else $error("store written outside execute step");
`endif

endmodule

// ----- tb/sv/nqt_checker.sv -----
// Scoreboard for the node quarantine table: tracks the table and checks every result.
`timescale 1ns / 100ps

module nqt_checker #(
    parameter int TABLE_DEPTH = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [1:0]        paddr,
    input  logic [31:0]       pwdata,
    input  logic              start,
    input  logic              busy,
    input  nqt_pkg::nqt_in_t  cmd,
    input  logic              done,
    input  nqt_pkg::nqt_out_t result,
    output int                fail_count,
    output int                outstanding,
    output int                checked
);
    import nqt_pkg::*;

    logic [1:0]    slot_state   [TABLE_DEPTH];
    logic [7:0]    slot_id      [TABLE_DEPTH];
    logic [1:0]    slot_motive  [TABLE_DEPTH];
    logic [TW-1:0] slot_arrival [TABLE_DEPTH];
    logic [TW-1:0] slot_judged  [TABLE_DEPTH];
    logic          admit_enable;

    nqt_out_t expected_q[$];
    nqt_out_t want;

    function automatic void clear_slot(input int i);
        slot_state[i]   = SLOT_EMPTY;
        slot_id[i]      = '0;
        slot_motive[i]  = MOT_UNKNOWN;
        slot_arrival[i] = '0;
        slot_judged[i]  = '0;
    endfunction

    // applies one action to the shadow table and returns the result it must produce
    function automatic nqt_out_t apply_action(input nqt_in_t c);
        nqt_out_t   r;
        logic [1:0] mot;
        int         hit;
        int         free_slot;
        int         active;
        r = '0;
        mot = (c.motive == MOT_INVALID) ? MOT_UNKNOWN : c.motive;
        hit = -1;
        free_slot = -1;
        active = 0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (hit < 0 && slot_state[i] != SLOT_EMPTY && slot_id[i] == c.node)
                hit = i;
            if (free_slot < 0 && slot_state[i] == SLOT_EMPTY)
                free_slot = i;
        end
        case (c.action)
            ACT_ADMIT:
            begin
                if (!admit_enable)
                    r.status = STS_MISS;
                else if (hit >= 0)
                begin
                    if (slot_state[hit] == SLOT_MALIC)
                        r.status = STS_REFUSED;
                    else if (slot_motive[hit] == MOT_UNKNOWN && mot != MOT_UNKNOWN)
                        slot_motive[hit] = mot;
                end
                else if (free_slot < 0)
                    r.status = STS_FULL;
                else
                begin
                    slot_state[free_slot]   = SLOT_VERIFY;
                    slot_id[free_slot]      = c.node;
                    slot_motive[free_slot]  = mot;
                    slot_arrival[free_slot] = c.now_ms;
                    slot_judged[free_slot]  = '0;
                end
            end
            ACT_VERDICT:
            begin
                if (hit < 0)
                    r.status = STS_MISS;
                else
                begin
                    slot_state[hit]  = c.verdict ? SLOT_MALIC : SLOT_CLEAN;
                    slot_judged[hit] = c.now_ms;
                end
            end
            ACT_EXPEL:
            begin
                if (hit < 0)
                    r.status = STS_MISS;
                else
                    clear_slot(hit);
            end
            default:
            begin
                if (hit < 0)
                    r.status = STS_MISS;
                else
                begin
                    r.entry_state  = slot_state[hit];
                    r.entry_motive = slot_motive[hit];
                    r.arrival_ms   = slot_arrival[hit];
                    r.verdict_ms   = slot_judged[hit];
                end
            end
        endcase
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (slot_state[i] == SLOT_VERIFY || slot_state[i] == SLOT_CLEAN)
                active++;
        end
        r.active_count = (active > 15) ? 4'd15 : active[3:0];
        return r;
    endfunction

    task automatic check_field(input string name, input logic [TW-1:0] exp_v,
                               input logic [TW-1:0] got_v);
        if (got_v !== exp_v)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_DEPTH; i++)
                clear_slot(i);
            admit_enable = 1'b0;
            expected_q.delete();
            fail_count  = 0;
            outstanding = 0;
            checked     = 0;
        end
        else
        begin
            // retire before accepting: done and a new accept can share an edge
            if (done)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("result with no transaction pending (status 0x%0h)",
                           result.status);
                    fail_count++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    check_field("status", TW'(want.status), TW'(result.status));
                    check_field("entry_state", TW'(want.entry_state),
                                TW'(result.entry_state));
                    check_field("entry_motive", TW'(want.entry_motive),
                                TW'(result.entry_motive));
                    check_field("arrival_ms",   want.arrival_ms,   result.arrival_ms);
                    check_field("verdict_ms",   want.verdict_ms,   result.verdict_ms);
                    check_field("active_count", TW'(want.active_count),
                                TW'(result.active_count));
                    checked++;
                end
            end
            if (psel && penable && pwrite && pready && paddr == REG_ENABLE)
                admit_enable = pwdata[0];
            if (start && !busy)
                expected_q.push_back(apply_action(cmd));
            outstanding = expected_q.size();
        end
    end

endmodule

// ----- tb/sv/node_quarantine_table_core_test.sv -----
// Testbench top for the node quarantine table: stimulus, register setup and verdict.
`timescale 1ns / 100ps

module node_quarantine_table_core_test;
    import nqt_pkg::*;

    localparam int DEPTH = 8;
    localparam int PHASE_ITEMS = 180;
    localparam logic [TW-1:0] T_MAX = {TW{1'b1}};

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        start;
    logic        busy;
    nqt_in_t     cmd;
    logic        done;
    nqt_out_t    result;

    int fail_count;
    int outstanding;
    int checked;

    bit         idle_on;
    logic [7:0] node_pool [12];
    int         action_count [4];
    int         reg_writes;

    node_quarantine_table_core #(.TABLE_DEPTH(DEPTH)) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .start   (start),
        .busy    (busy),
        .cmd     (cmd),
        .done    (done),
        .result  (result)
    );

    nqt_checker #(.TABLE_DEPTH(DEPTH)) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .done        (done),
        .result      (result),
        .fail_count  (fail_count),
        .outstanding (outstanding),
        .checked     (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #(6_000_000);
        $display("simulation failed");
        $finish;
    end

    function automatic nqt_in_t make_action(input logic [1:0] act, input logic [7:0] id,
                                            input logic [1:0] mot, input logic vrd,
                                            input logic [TW-1:0] stamp);
        nqt_in_t c;
        c.action  = act;
        c.node    = id;
        c.motive  = mot;
        c.verdict = vrd;
        c.now_ms  = stamp;
        return c;
    endfunction

    function automatic logic [TW-1:0] random_stamp();
        logic [63:0] w;
        w = {$urandom, $urandom};
        case ($urandom_range(9))
            0: return '0;
            1: return T_MAX;
            default: return w[TW-1:0];
        endcase
    endfunction

    // mostly ids from a small pool so admits, verdicts and expels hit live entries
    function automatic nqt_in_t random_action();
        int         pick;
        logic [7:0] id;
        logic [1:0] act;
        pick = $urandom_range(99);
        if (pick < 35)
            act = ACT_ADMIT;
        else if (pick < 55)
            act = ACT_VERDICT;
        else if (pick < 72)
            act = ACT_EXPEL;
        else
            act = ACT_QUERY;
        if ($urandom_range(99) < 85)
            id = node_pool[$urandom_range(11)];
        else
            id = 8'($urandom_range(255));
        return make_action(act, id, 2'($urandom_range(3)), 1'($urandom_range(1)),
                           random_stamp());
    endfunction

    task automatic send_action(input nqt_in_t c);
        int gap;
        if (idle_on && $urandom_range(99) < 38)
        begin
            gap = $urandom_range(1, 8);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        do @(posedge clk); while (busy);
        action_count[c.action]++;
    endtask

    // hold off until every transaction in flight has returned its result
    task automatic drain();
        start <= 1'b0;
        do @(negedge clk); while (outstanding != 0);
    endtask

    task automatic apb_write(input logic [1:0] addr, input logic [31:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        reg_writes++;
    endtask

    task automatic set_enable(input logic en);
        logic [31:0] w;
        drain();
        w = $urandom;
        w[0] = en;
        apb_write(REG_ENABLE, w);
    endtask

    initial
    begin
        logic en_plan [6];
        rst_n   = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        start   = 1'b0;
        cmd     = '0;
        idle_on = 1'b1;
        reg_writes = 0;
        for (int i = 0; i < 4; i++)
            action_count[i] = 0;
        en_plan = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // disabled after reset: admit is not taken, and the empty table misses everywhere
        send_action(make_action(ACT_ADMIT,   8'd5, 2'd1, 1'b0, 48'h1));
        send_action(make_action(ACT_QUERY,   8'd5, 2'd0, 1'b0, 48'h2));
        send_action(make_action(ACT_VERDICT, 8'd5, 2'd0, 1'b1, 48'h3));
        send_action(make_action(ACT_EXPEL,   8'd5, 2'd0, 1'b0, 48'h4));
        set_enable(1'b1);
        send_action(make_action(ACT_ADMIT,   8'd0,   2'd0, 1'b0, '0));
        send_action(make_action(ACT_ADMIT,   8'd255, 2'd2, 1'b1, T_MAX));
        send_action(make_action(ACT_ADMIT,   8'd0,   2'd1, 1'b0, 48'h10));   // refine
        send_action(make_action(ACT_ADMIT,   8'd0,   2'd2, 1'b0, 48'h11));   // already set
        send_action(make_action(ACT_ADMIT,   8'd7,   2'd3, 1'b0, 48'hAAAA_5555_0F0F));
        send_action(make_action(ACT_QUERY,   8'd7,   2'd1, 1'b1, 48'h0));
        send_action(make_action(ACT_ADMIT,   8'd7,   2'd1, 1'b0, 48'h20));
        send_action(make_action(ACT_QUERY,   8'd0,   2'd0, 1'b0, 48'h21));
        send_action(make_action(ACT_VERDICT, 8'd0,   2'd0, 1'b0, 48'h5555_AAAA_F0F0));
        send_action(make_action(ACT_VERDICT, 8'd255, 2'd0, 1'b1, T_MAX));
        send_action(make_action(ACT_ADMIT,   8'd255, 2'd1, 1'b0, 48'h30));   // malicious
        send_action(make_action(ACT_QUERY,   8'd255, 2'd0, 1'b0, 48'h31));
        for (int i = 1; i <= 5; i++)
            send_action(make_action(ACT_ADMIT, i[7:0], i[1:0], 1'b0, 48'h100 + i));
        send_action(make_action(ACT_ADMIT,   8'd9,   2'd2, 1'b0, 48'h200));  // full
        send_action(make_action(ACT_EXPEL,   8'd3,   2'd0, 1'b0, 48'h201));
        send_action(make_action(ACT_ADMIT,   8'd9,   2'd2, 1'b0, 48'h202));
        send_action(make_action(ACT_EXPEL,   8'd200, 2'd0, 1'b0, 48'h203));
        send_action(make_action(ACT_VERDICT, 8'd7,   2'd0, 1'b1, 48'h300));
        send_action(make_action(ACT_VERDICT, 8'd7,   2'd0, 1'b0, 48'h301));
        send_action(make_action(ACT_QUERY,   8'd7,   2'd0, 1'b0, 48'h302));

        for (int p = 0; p < 6; p++)
        begin
            set_enable(en_plan[p]);
            node_pool[0] = 8'd0;
            node_pool[1] = 8'd255;
            for (int k = 2; k < 12; k++)
                node_pool[k] = 8'($urandom_range(255));
            idle_on = (p != 3);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n == PHASE_ITEMS / 2)
                    drain();
                send_action(random_action());
            end
        end

        drain();
        repeat (DEPTH + 4) @(posedge clk);
        @(negedge clk);
        $display("covered %0d admit, %0d verdict, %0d expel, %0d query transactions",
                 action_count[ACT_ADMIT], action_count[ACT_VERDICT],
                 action_count[ACT_EXPEL], action_count[ACT_QUERY]);
        $display("%0d results checked across %0d enable register writes",
                 checked, reg_writes);
        if (fail_count == 0 && outstanding == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/nqt_pkg.sv
hdl/nqt_apb.sv
hdl/nqt_store.sv
hdl/node_quarantine_table_core.sv
tb/sv/nqt_checker.sv
tb/sv/node_quarantine_table_core_test.sv
